// ===== src/cvm_pkg.sv =====
// Package with the widths, types and helpers shared by the CORDIC magnitude pipeline.
`default_nettype none

package cvm_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int MAG_WIDTH  = DATA_WIDTH - 1;
   localparam int MAX_ROUNDS = 31;
   localparam int CNT_WIDTH  = 5;

   typedef logic signed [DATA_WIDTH-1:0] coord_type;
   typedef logic [MAG_WIDTH-1:0]         mag_type;
   typedef logic [CNT_WIDTH-1:0]         count_type;

   typedef struct packed {
      mag_type x;
      mag_type y;
   } pair_type;

   typedef struct packed {
      logic load;
      logic valid;
   } stage_ctl_type;

   function automatic mag_type half_abs(input coord_type value);
      logic [DATA_WIDTH-1:0] mag;
      mag = value[DATA_WIDTH-1] ? (~value + 1'b1) : value;
      return mag[DATA_WIDTH-1:1];
   endfunction

endpackage

`default_nettype wire

// ===== src/cordic_vector_magnitude.sv =====
// Top level of the pipelined CORDIC vector magnitude unit.
// The unit takes one (x, y) transfer per clock while req_stall is low and returns the
// unscaled magnitude (half the true length times the CORDIC gain of about 1.164) after one
// entry stage for absolute value, halving and ordering, then one register stage per round for
// all 31 possible rounds; rounds beyond csr_write_data's stored count pass data unchanged.
// A stalled output only holds back the stages behind it that are full, so empty slots keep
// taking new transfers; req_stall rises only when every stage holds an item.
// The round count register resets to 16 and should be written only while the pipeline is empty.
`default_nettype none

module cordic_vector_magnitude
   import cvm_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      csr_write_enable,
   input  wire count_type csr_write_data,
   input  wire logic      req_valid,
   output logic           req_stall,
   input  wire coord_type req_coord_x,
   input  wire coord_type req_coord_y,
   output logic           rsp_valid,
   input  wire logic      rsp_stall,
   output mag_type        rsp_magnitude
);

   count_type     round_count_ff;
   logic          valid_s [0:MAX_ROUNDS];
   pair_type      pair_s  [0:MAX_ROUNDS];
   logic          adv     [0:MAX_ROUNDS];
   stage_ctl_type ctl     [0:MAX_ROUNDS];

   always_ff @(posedge clock) begin
      if (reset) begin
         round_count_ff <= count_type'(16);
      end else if (csr_write_enable) begin
         round_count_ff <= csr_write_data;
      end
   end

   always_comb begin
      adv[MAX_ROUNDS] = !valid_s[MAX_ROUNDS] || !rsp_stall;
      for (int k = MAX_ROUNDS - 1; k >= 0; k--) begin
         adv[k] = !valid_s[k] || adv[k+1];
      end
   end

   always_comb begin
      ctl[0].load  = adv[0];
      ctl[0].valid = req_valid;
      for (int k = 1; k <= MAX_ROUNDS; k++) begin
         ctl[k].load  = adv[k];
         ctl[k].valid = valid_s[k-1];
      end
   end

   cvm_prep u_prep (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl[0]),
      .coord_x (req_coord_x),
      .coord_y (req_coord_y),
      .valid   (valid_s[0]),
      .pair    (pair_s[0])
   );

   for (genvar g = 1; g <= MAX_ROUNDS; g++) begin : g_round
      cvm_round u_round (
         .clock  (clock),
         .reset  (reset),
         .ctl    (ctl[g]),
         .shift  (count_type'(g)),
         .active (count_type'(g) <= round_count_ff),
         .pair_i (pair_s[g-1]),
         .valid  (valid_s[g]),
         .pair_o (pair_s[g])
      );
   end

   assign req_stall     = !adv[0];
   assign rsp_valid     = valid_s[MAX_ROUNDS];
   assign rsp_magnitude = pair_s[MAX_ROUNDS].x;

   a_reset_empties: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("Result valid after reset.");

   a_stall_only_when_blocked: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("Input stalled while output is free.");

   a_free_output_frees_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall) |-> !req_stall)
      else $error("Input stalled although the output drains.");

endmodule

`default_nettype wire

// ===== src/cvm_prep.sv =====
// Entry stage: absolute value, halving and ordering of the two coordinates.
`default_nettype none

module cvm_prep
   import cvm_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire stage_ctl_type ctl,
   input  wire coord_type     coord_x,
   input  wire coord_type     coord_y,
   output logic               valid,
   output pair_type          pair
);

   logic     valid_ff;
   pair_type pair_ff;
   pair_type pair_in;
   mag_type  ax;
   mag_type  ay;

   always_comb begin
      ax = half_abs(coord_x);
      ay = half_abs(coord_y);
      if (ay > ax) begin
         pair_in.x = ay;
         pair_in.y = ax;
      end else begin
         pair_in.x = ax;
         pair_in.y = ay;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl.load) begin
         valid_ff <= ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         pair_ff <= pair_in;
      end
   end

   assign valid = valid_ff;
   assign pair  = pair_ff;

endmodule

`default_nettype wire

// ===== src/cvm_round.sv =====
// One CORDIC vectoring round, or a pass-through when not active, held in its own pipeline register.
`default_nettype none

module cvm_round
   import cvm_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire stage_ctl_type ctl,
   input  wire count_type     shift,
   input  wire logic          active,
   input  wire pair_type      pair_i,
   output logic               valid,
   output pair_type          pair_o
);

   logic     valid_ff;
   pair_type pair_ff;
   pair_type pair_in;
   mag_type  sx;
   mag_type  sy;

   always_comb begin
      sx = pair_i.x >> shift;
      sy = pair_i.y >> shift;
      if (active) begin
         pair_in.x = pair_i.x + sy;
         pair_in.y = (pair_i.y >= sx) ? (pair_i.y - sx) : (sx - pair_i.y);
      end else begin
         pair_in = pair_i;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl.load) begin
         valid_ff <= ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         pair_ff <= pair_in;
      end
   end

   assign valid  = valid_ff;
   assign pair_o = pair_ff;

endmodule

`default_nettype wire
